### rtl/ftt_pkg.sv
package ftt_pkg;

   localparam int TAP_SLOTS_DEFAULT = 10;

   localparam int POS_W      = 8;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_W      = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
   localparam int STEP_W     = 4;

   localparam logic [DIV_W-1:0] RATE_NUMERATOR = DIV_W'(60000);
   localparam logic [POS_W-1:0] POS_FULL       = '1;

   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_PRESS   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_TOGGLE  = 2'd3
   } ftt_op_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_FLASH  = 2'd1,
      MODE_TEMPO  = 2'd2,
      MODE_UNUSED = 2'd3
   } ftt_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_MODE     = 2'd0,
      CSR_MIN_INTERVAL = 2'd1,
      CSR_MAX_INTERVAL = 2'd2,
      CSR_STEP_THRESH  = 2'd3
   } ftt_csr_type;

   typedef enum logic [3:0] {
      U_NOP        = 4'd0,
      U_DIFF       = 4'd1,
      U_TAP_CHECK  = 4'd2,
      U_DIV_RATE   = 4'd3,
      U_DIV_STEP   = 4'd4,
      U_RING_WRITE = 4'd5,
      U_RD_FIRST   = 4'd6,
      U_ACC        = 4'd7,
      U_DIV_AVG    = 4'd8,
      U_AVG_STORE  = 4'd9,
      U_EMIT       = 4'd10,
      U_SIMPLE     = 4'd11
   } ftt_uop_type;

   typedef enum logic [2:0] {
      C_NEXT      = 3'd0,
      C_ALWAYS    = 3'd1,
      C_NO_START  = 3'd2,
      C_NOT_TEMPO = 3'd3,
      C_NO_RATE   = 3'd4,
      C_DIV_MORE  = 3'd5,
      C_SUM_MORE  = 3'd6,
      C_OUT_FULL  = 3'd7
   } ftt_cond_type;

   typedef struct packed {
      ftt_uop_type          uop;
      ftt_cond_type         cond;
      logic [STEP_W-1:0]    target;
   } ftt_ucode_type;

   typedef struct packed {
      logic not_tempo;
      logic no_rate;
      logic div_more;
      logic sum_more;
   } ftt_status_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             position_changed;
      logic             single_step;
      logic             tempo_updated;
   } ftt_result_type;

   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DIFF      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_TAP_CHECK = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DIV_RATE  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_RATE_LOOP = 4'd4;
   localparam logic [STEP_W-1:0] STEP_RING_WR   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_RD_FIRST  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_ACC       = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DIV_AVG   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_AVG_LOOP  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_AVG_STORE = 4'd10;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd11;
   localparam logic [STEP_W-1:0] STEP_DONE      = 4'd12;
   localparam logic [STEP_W-1:0] STEP_SIMPLE    = 4'd13;

endpackage

### rtl/ftt_useq.sv
module ftt_useq
   import ftt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           out_free,
   input  ftt_status_type status,
   output ftt_uop_type    uop,
   output logic           idle
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ftt_ucode_type     ucode;
   logic              jump;

   function automatic ftt_ucode_type rom(input logic [STEP_W-1:0] addr);
      ftt_ucode_type w;
      begin
         unique case (addr)
            STEP_IDLE:      w = '{U_NOP,        C_NO_START,  STEP_IDLE};
            STEP_DIFF:      w = '{U_DIFF,       C_NOT_TEMPO, STEP_SIMPLE};
            STEP_TAP_CHECK: w = '{U_TAP_CHECK,  C_NO_RATE,   STEP_EMIT};
            STEP_DIV_RATE:  w = '{U_DIV_RATE,   C_NEXT,      STEP_IDLE};
            STEP_RATE_LOOP: w = '{U_DIV_STEP,   C_DIV_MORE,  STEP_RATE_LOOP};
            STEP_RING_WR:   w = '{U_RING_WRITE, C_NEXT,      STEP_IDLE};
            STEP_RD_FIRST:  w = '{U_RD_FIRST,   C_NEXT,      STEP_IDLE};
            STEP_ACC:       w = '{U_ACC,        C_SUM_MORE,  STEP_ACC};
            STEP_DIV_AVG:   w = '{U_DIV_AVG,    C_NEXT,      STEP_IDLE};
            STEP_AVG_LOOP:  w = '{U_DIV_STEP,   C_DIV_MORE,  STEP_AVG_LOOP};
            STEP_AVG_STORE: w = '{U_AVG_STORE,  C_NEXT,      STEP_IDLE};
            STEP_EMIT:      w = '{U_EMIT,       C_OUT_FULL,  STEP_EMIT};
            STEP_DONE:      w = '{U_NOP,        C_ALWAYS,    STEP_IDLE};
            STEP_SIMPLE:    w = '{U_SIMPLE,     C_ALWAYS,    STEP_EMIT};
            default:        w = '{U_NOP,        C_ALWAYS,    STEP_IDLE};
         endcase
         return w;
      end
   endfunction

   assign ucode = rom(step_ff);
   assign uop   = ucode.uop;
   assign idle  = (step_ff == STEP_IDLE);

   always_comb begin
      unique case (ucode.cond)
         C_NEXT:      jump = 1'b0;
         C_ALWAYS:    jump = 1'b1;
         C_NO_START:  jump = !start;
         C_NOT_TEMPO: jump = status.not_tempo;
         C_NO_RATE:   jump = status.no_rate;
         C_DIV_MORE:  jump = status.div_more;
         C_SUM_MORE:  jump = status.sum_more;
         C_OUT_FULL:  jump = !out_free;
         default:     jump = 1'b1;
      endcase
      step_in = jump ? ucode.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/ftt_datapath.sv
module ftt_datapath
   import ftt_pkg::*;
#(
   parameter int TAP_SLOTS = TAP_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            op,
   input  logic [POS_W-1:0]      new_position,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  ftt_uop_type           uop,
   output ftt_status_type        status,
   output ftt_result_type        result
);

   localparam int SLOT_W = $clog2(TAP_SLOTS);
   localparam int FILL_W = $clog2(TAP_SLOTS + 1);
   localparam int SUM_W  = $clog2(255 * TAP_SLOTS + 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TAP_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TAP_SLOTS - 1);

   logic [1:0]            mode_ff;
   logic [INTERVAL_W-1:0] min_ff;
   logic [INTERVAL_W-1:0] max_ff;
   logic [POS_W-1:0]      thresh_ff;

   ftt_op_type            op_ff;
   logic [POS_W-1:0]      newpos_ff;
   logic [TIME_W-1:0]     now_ff;

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]      saved_ff, saved_in;
   logic                  flash_ff, flash_in;
   logic                  zero_ff, zero_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic                  step_ff, step_in;
   logic                  tempo_ff, tempo_in;

   logic [POS_W-1:0]      before_ff, before_in;
   logic [TIME_W-1:0]     diff_ff, diff_in;
   logic [FILL_W-1:0]     idx_ff, idx_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;

   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DIV_W-1:0]      dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W:0]        shifted;
   logic [DIV_W+1:0]      trial;

   logic [POS_W-1:0]      ring [TAP_SLOTS];
   logic [POS_W-1:0]      ring_rd_ff;
   logic                  ring_we;
   logic                  ring_re;
   logic [SLOT_W-1:0]     ring_rd_addr;
   logic [POS_W-1:0]      rate_sat;

   logic                  diff_above_min;
   logic                  diff_below_max;
   logic                  below_thresh;

   assign diff_above_min = diff_ff > TIME_W'(min_ff);
   assign diff_below_max = diff_ff < TIME_W'(max_ff);
   assign below_thresh   = pos_ff < thresh_ff;

   assign status.not_tempo = !(op_ff == OP_PRESS && mode_ff == MODE_TEMPO);
   assign status.no_rate   = below_thresh || !diff_above_min || !diff_below_max;
   assign status.div_more  = (cnt_ff != DIV_CNT_W'(1));
   assign status.sum_more  = (idx_ff < fill_ff);

   assign result.position         = pos_ff;
   assign result.position_changed = (pos_ff != before_ff);
   assign result.single_step      = step_ff;
   assign result.tempo_updated    = tempo_ff;

   assign shifted  = {rem_ff, quo_ff[DIV_W-1]};
   assign trial    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign rate_sat = (quo_ff[DIV_W-1:POS_W] != '0) ? POS_FULL : quo_ff[POS_W-1:0];
   assign ring_rd_addr = idx_ff[SLOT_W-1:0];

   always_comb begin
      pos_in    = pos_ff;
      saved_in  = saved_ff;
      flash_in  = flash_ff;
      zero_in   = zero_ff;
      fill_in   = fill_ff;
      slot_in   = slot_ff;
      last_in   = last_ff;
      step_in   = step_ff;
      tempo_in  = tempo_ff;
      before_in = before_ff;
      diff_in   = diff_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      ring_we   = 1'b0;
      ring_re   = 1'b0;
      unique case (uop)
         U_DIFF: begin
            diff_in   = now_ff - last_ff;
            before_in = pos_ff;
            step_in   = 1'b0;
            tempo_in  = 1'b0;
         end
         U_TAP_CHECK: begin
            last_in = now_ff;
            if (below_thresh) begin
               step_in = 1'b1;
            end else if (diff_above_min && !diff_below_max) begin
               fill_in = '0;
               slot_in = '0;
            end
         end
         U_DIV_RATE: begin
            rem_in = '0;
            quo_in = RATE_NUMERATOR;
            dvs_in = diff_ff[DIV_W-1:0];
            cnt_in = DIV_CNT_W'(DIV_W);
         end
         U_DIV_STEP: begin
            cnt_in = cnt_ff - DIV_CNT_W'(1);
            if (!trial[DIV_W+1]) begin
               rem_in = trial[DIV_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DIV_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
         U_RING_WRITE: begin
            ring_we = 1'b1;
            slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
            if (fill_ff < FILL_MAX) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            sum_in = '0;
            idx_in = '0;
         end
         U_RD_FIRST: begin
            ring_re = 1'b1;
            idx_in  = FILL_W'(1);
         end
         U_ACC: begin
            sum_in = sum_ff + SUM_W'(ring_rd_ff);
            if (idx_ff < fill_ff) begin
               ring_re = 1'b1;
               idx_in  = idx_ff + FILL_W'(1);
            end
         end
         U_DIV_AVG: begin
            rem_in = '0;
            quo_in = DIV_W'(sum_ff);
            dvs_in = DIV_W'(fill_ff);
            cnt_in = DIV_CNT_W'(DIV_W);
         end
         U_AVG_STORE: begin
            pos_in   = quo_ff[POS_W-1:0];
            saved_in = quo_ff[POS_W-1:0];
            tempo_in = 1'b1;
         end
         U_SIMPLE: begin
            unique case (op_ff)
               OP_SET: begin
                  pos_in = newpos_ff;
               end
               OP_PRESS: begin
                  if (mode_ff == MODE_FLASH && !flash_ff) begin
                     saved_in = pos_ff;
                     pos_in   = POS_FULL;
                     flash_in = 1'b1;
                  end
               end
               OP_RELEASE: begin
                  if (mode_ff == MODE_FLASH) begin
                     if (flash_ff && pos_ff == POS_FULL) begin
                        pos_in = saved_ff;
                     end
                     flash_in = 1'b0;
                  end
               end
               OP_TOGGLE: begin
                  if (!zero_ff) begin
                     saved_in = pos_ff;
                     pos_in   = '0;
                  end else begin
                     pos_in = saved_ff;
                  end
                  zero_in = !zero_ff;
               end
               default: begin
                  pos_in = pos_ff;
               end
            endcase
         end
         U_NOP, U_EMIT: begin
            pos_in = pos_ff;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FLASH;
         min_ff    <= INTERVAL_W'(240);
         max_ff    <= INTERVAL_W'(2000);
         thresh_ff <= POS_W'(5);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_MODE:     mode_ff   <= csr_wdata[1:0];
            CSR_MIN_INTERVAL: min_ff    <= csr_wdata[INTERVAL_W-1:0];
            CSR_MAX_INTERVAL: max_ff    <= csr_wdata[INTERVAL_W-1:0];
            CSR_STEP_THRESH:  thresh_ff <= csr_wdata[POS_W-1:0];
            default:          mode_ff   <= mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff     <= ftt_op_type'(op);
         newpos_ff <= new_position;
         now_ff    <= now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         saved_ff <= '0;
         flash_ff <= 1'b0;
         zero_ff  <= 1'b0;
         fill_ff  <= '0;
         slot_ff  <= '0;
         last_ff  <= '0;
         step_ff  <= 1'b0;
         tempo_ff <= 1'b0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         saved_ff <= saved_in;
         flash_ff <= flash_in;
         zero_ff  <= zero_in;
         fill_ff  <= fill_in;
         slot_ff  <= slot_in;
         last_ff  <= last_in;
         step_ff  <= step_in;
         tempo_ff <= tempo_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      before_ff <= before_in;
      diff_ff   <= diff_in;
      sum_ff    <= sum_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[slot_ff] <= rate_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_re) begin
         ring_rd_ff <= ring[ring_rd_addr];
      end
   end

   // While the ring is still filling, the write slot always equals the fill count.
   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < FILL_MAX) |-> (FILL_W'(slot_ff) == fill_ff))
      else $error("tap slot and fill count disagree");

   a_fill_after_write: assert property (@(posedge clock) disable iff (reset)
      (uop == U_RING_WRITE) |=> (fill_ff != '0 && fill_ff <= FILL_MAX))
      else $error("fill count out of range after ring write");

   a_rate_divisor: assert property (@(posedge clock) disable iff (reset)
      (uop == U_DIV_RATE) |-> (diff_ff != '0 && diff_ff[TIME_W-1:DIV_W] == '0))
      else $error("tap interval unfit for rate division");

   a_avg_fits: assert property (@(posedge clock) disable iff (reset)
      (uop == U_AVG_STORE) |-> (quo_ff[DIV_W-1:POS_W] == '0))
      else $error("tap average exceeds position range");

endmodule

### rtl/fader_tap_flash_tempo.sv
// Fader position with direct set, tap press, tap release and off toggle, including
// flash-to-full and tempo tap averaging over a ring of TAP_SLOTS rate entries. One
// request beat gives exactly one response beat. A set, toggle, release or flash press
// takes the simple path, and an ignored or single-step tap goes straight to the
// response; an averaging tap also takes the mean over the filled ring entries, counting
// the one just written. The sequencer waits while the response register is full and
// stalled. In the microcoded sequencer, a shared 16-step restoring divider runs once
// for 60000/interval and once for the mean, and the ring is read one entry per cycle
// to form the sum. The response register frees the sequencer as soon as it loads, so
// a stalled response holds only the next result, not the next request.
module fader_tap_flash_tempo
   import ftt_pkg::*;
#(
   parameter int TAP_SLOTS = TAP_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [POS_W-1:0]      req_new_position,
   input  logic [TIME_W-1:0]     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_W-1:0]      rsp_position,
   output logic                  rsp_position_changed,
   output logic                  rsp_single_step,
   output logic                  rsp_tempo_updated,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ftt_uop_type    uop;
   ftt_status_type status;
   ftt_result_type result;
   logic           idle;
   logic           start;
   logic           out_free;
   logic           emit;
   logic           rsp_valid_ff, rsp_valid_in;
   ftt_result_type rsp_data_ff;

   assign start     = req_valid && idle;
   assign req_stall = !idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (uop == U_EMIT) && out_free;

   ftt_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .status   (status),
      .uop      (uop),
      .idle     (idle)
   );

   ftt_datapath #(
      .TAP_SLOTS (TAP_SLOTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .op           (req_op),
      .new_position (req_new_position),
      .now_ms       (req_now_ms),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .uop          (uop),
      .status       (status),
      .result       (result)
   );

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position         = rsp_data_ff.position;
   assign rsp_position_changed = rsp_data_ff.position_changed;
   assign rsp_single_step      = rsp_data_ff.single_step;
   assign rsp_tempo_updated    = rsp_data_ff.tempo_updated;

endmodule
